// ===== rtl/pilt_pkg.sv =====
`default_nettype none
package pilt_pkg;

  localparam int PosW = 6;
  localparam int DataW = 32;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_GET    = 3'd2;
  localparam logic [2:0] CMD_LOCATE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  typedef struct packed {
    logic [2:0]              command;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] item_value;
  } pilt_cmd_t;

  typedef struct packed {
    logic                    status;
    logic signed [DataW-1:0] read_value;
    logic [PosW-1:0]         found_position;
    logic [PosW-1:0]         list_length;
    logic                    list_empty;
  } pilt_res_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic [1:0]       op;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] data;
  } pilt_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/pilt_if.sv =====
`default_nettype none
interface pilt_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/position_indexed_list_table.sv =====
// Insert, delete, get, clear: result registered in res_r, then in out_r, and offered on out_ch;
// one command per cycle while the result side keeps up, held off once both result
// registers are full. Locate compares all cells at once, then scans the match vector
// eight cells a cycle, with no new command taken until the scan ends; its result then
// goes through the same result registers once res_r is free.
// Reset (rst_n low, synchronous) empties the list and drops pending results.
`default_nettype none
module position_indexed_list_table #(
  parameter int CAPACITY = 32
) (
  input  wire     clk,
  input  wire     rst_n,
  pilt_if.sink    in_ch,
  pilt_if.source  out_ch
);
  import pilt_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int NGRP = (CAPACITY + 7) / 8;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  pilt_cmd_t  cmd;
  pilt_ctrl_t ctrl;

  logic [DataW-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [GW-1:0] grp_r, grp_nxt;
  logic [NGRP*8-1:0] match_r, match_nxt;
  logic          res_valid_r, res_valid_nxt;
  pilt_res_t     res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  pilt_res_t     out_r, out_nxt;

  logic        accept;
  logic        res_move;
  logic        res_free;
  logic [31:0] pos32, cnt32, cnt_after, pm1, found32;
  logic [IW-1:0] rd_idx;
  logic        pos_in_list;
  logic [7:0]  grp_bits;
  logic        grp_hit;
  logic [2:0]  hit_idx;
  logic        grp_last;

  assign cmd      = in_ch.payload;
  assign res_move = res_valid_r && (!out_valid_r || out_ch.ready);
  assign res_free = !res_valid_r || res_move;
  assign in_ch.ready = (state_r == S_IDLE) && res_free;
  assign accept   = in_ch.valid && in_ch.ready;

  assign pos32  = 32'(cmd.position);
  assign cnt32  = 32'(count_r);
  assign pm1    = pos32 - 32'd1;
  assign rd_idx = pm1[IW-1:0];
  assign pos_in_list = (pos32 >= 32'd1) && (pos32 <= cnt32);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DataW-1:0] left_v, right_v;
      if (gi == 0) begin : g_first
        assign left_v = '0;
      end else begin : g_mid_l
        assign left_v = cell_val[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_mid_r
        assign right_v = cell_val[gi+1];
      end
      pilt_cell #(.INDEX(gi)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .left_in   (left_v),
        .right_in  (right_v),
        .value_out (cell_val[gi]),
        .match_out (cell_match[gi])
      );
    end
  endgenerate

  // Lowest set bit of the current group of the match vector.
  always_comb begin
    grp_bits = match_r[{grp_r, 3'b000} +: 8];
    grp_hit  = |grp_bits;
    hit_idx  = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (grp_bits[b]) begin
        hit_idx = 3'(b);
      end
    end
  end

  assign grp_last = (grp_r == GW'(NGRP - 1));
  assign found32  = 32'({grp_r, hit_idx}) + 32'd1;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    grp_nxt       = grp_r;
    match_nxt     = match_r;
    res_valid_nxt = res_move ? 1'b0 : res_valid_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ctrl.op       = OP_HOLD;
    ctrl.pos      = cmd.position;
    ctrl.data     = cmd.item_value;
    cnt_after     = cnt32;

    if (res_move) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res_r;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      res_nxt.status         = 1'b1;
      res_nxt.read_value     = '0;
      res_nxt.found_position = '0;
      unique case (cmd.command)
        CMD_INSERT: begin
          if ((cnt32 < 32'(CAPACITY)) && (pos32 >= 32'd1) &&
              (pos32 <= cnt32 + 32'd1)) begin
            ctrl.op        = OP_INS;
            cnt_after      = cnt32 + 32'd1;
            res_nxt.status = 1'b0;
          end
        end
        CMD_DELETE: begin
          if (pos_in_list) begin
            ctrl.op            = OP_DEL;
            cnt_after          = cnt32 - 32'd1;
            res_nxt.read_value = cell_val[rd_idx];
            res_nxt.status     = 1'b0;
          end
        end
        CMD_GET: begin
          if (pos_in_list) begin
            res_nxt.read_value = cell_val[rd_idx];
            res_nxt.status     = 1'b0;
          end
        end
        CMD_LOCATE: begin
          res_nxt.status = 1'b0;
        end
        CMD_CLEAR: begin
          cnt_after      = 32'd0;
          res_nxt.status = 1'b0;
        end
        default: res_nxt.status = 1'b1;
      endcase
      count_nxt            = cnt_after[CW-1:0];
      res_nxt.list_length  = cnt_after[PosW-1:0];
      res_nxt.list_empty   = (cnt_after == 32'd0);

      if (cmd.command == CMD_LOCATE) begin
        // Only entries below the current length may match.
        state_nxt = S_SCAN;
        grp_nxt   = '0;
        match_nxt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
          match_nxt[i] = cell_match[i] && (32'(i) < cnt32);
        end
      end else begin
        res_valid_nxt = 1'b1;
      end
    end else if (state_r == S_SCAN) begin
      if (grp_hit || grp_last) begin
        if (res_free) begin
          res_valid_nxt          = 1'b1;
          res_nxt.found_position = grp_hit ? found32[PosW-1:0] : '0;
          state_nxt              = S_IDLE;
        end
      end else begin
        grp_nxt = grp_r + GW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      grp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
      grp_r       <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (state_r == S_IDLE))
    else $error("transfer accepted during a locate scan");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("list length above capacity");

  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd.command != CMD_LOCATE)) |=> res_valid_r)
    else $error("result missing after a direct command");

  a_locate_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd.command == CMD_LOCATE)) |=> (state_r == S_SCAN))
    else $error("locate did not start a scan");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.list_empty) |-> (out_r.list_length == '0))
    else $error("empty flag with nonzero length");

endmodule
`default_nettype wire

// ===== rtl/pilt_cell.sv =====
`default_nettype none
module pilt_cell #(
  parameter int INDEX = 0
) (
  input  wire                        clk,
  input  pilt_pkg::pilt_ctrl_t       ctrl,
  input  wire [pilt_pkg::DataW-1:0]  left_in,
  input  wire [pilt_pkg::DataW-1:0]  right_in,
  output logic [pilt_pkg::DataW-1:0] value_out,
  output logic                       match_out
);
  import pilt_pkg::*;

  logic [DataW-1:0] value_r;
  logic [DataW-1:0] value_nxt;
  logic [31:0]      slot;
  logic [31:0]      pos32;

  assign slot  = 32'(INDEX + 1);
  assign pos32 = 32'(ctrl.pos);

  always_comb begin
    value_nxt = value_r;
    unique case (ctrl.op)
      OP_INS: begin
        if (slot > pos32) begin
          value_nxt = left_in;
        end else if (slot == pos32) begin
          value_nxt = ctrl.data;
        end
      end
      OP_DEL: begin
        if (slot >= pos32) begin
          value_nxt = right_in;
        end
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_out = value_r;
  assign match_out = (value_r == ctrl.data);

endmodule
`default_nettype wire

// ===== bench/position_indexed_list_table_tb.sv =====
`timescale 1ns / 1ps
module position_indexed_list_table_tb;
  import pilt_pkg::*;

  localparam int          LIST_DEPTH   = 32;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          SETTLE_TICKS = 20;
  localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STARVED} rx_mode_t;
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_t;

  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  pilt_if #(.payload_t(pilt_cmd_t)) cmd_bus ();
  pilt_if #(.payload_t(pilt_res_t)) reply_bus ();

  position_indexed_list_table #(.CAPACITY(LIST_DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_bus),
    .out_ch (reply_bus)
  );

  pilt_cmd_t               queued_cmds[$];
  pilt_res_t               list_replies_due[$];
  logic signed [DataW-1:0] shadow_list[$];
  logic signed [DataW-1:0] value_pool[8];
  int                      gen_len;
  int                      fail_count;
  int                      cycle_count;
  int                      burst_left;
  int                      gap_left;
  rx_mode_t                rx_mode;
  int                      rx_mode_left;
  pilt_res_t               want;
  pilt_res_t               got;

  // Predicts the reply to one command and updates the shadow copy of the list.
  function automatic pilt_res_t apply_list_cmd(pilt_cmd_t c);
    pilt_res_t r;
    int        len;
    int        p;
    r   = '0;
    r.status = 1'b1;
    len = shadow_list.size();
    p   = c.position;
    case (c.command)
      CMD_INSERT: begin
        if (len < LIST_DEPTH && p >= 1 && p <= len + 1) begin
          shadow_list.insert(p - 1, c.item_value);
          r.status = 1'b0;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= len) begin
          r.read_value = shadow_list[p - 1];
          shadow_list.delete(p - 1);
          r.status = 1'b0;
        end
      end
      CMD_GET: begin
        if (p >= 1 && p <= len) begin
          r.read_value = shadow_list[p - 1];
          r.status = 1'b0;
        end
      end
      CMD_LOCATE: begin
        for (int k = 0; k < len; k++) begin
          if (shadow_list[k] == c.item_value && r.found_position == 0) begin
            r.found_position = PosW'(k + 1);
          end
        end
        r.status = 1'b0;
      end
      CMD_CLEAR: begin
        shadow_list.delete();
        r.status = 1'b0;
      end
      default: ;
    endcase
    r.list_length = PosW'(shadow_list.size());
    r.list_empty  = (shadow_list.size() == 0);
    return r;
  endfunction

  function automatic void queue_cmd(logic [2:0] cmd, int pos, logic signed [DataW-1:0] val);
    pilt_cmd_t c;
    c.command    = cmd;
    c.position   = PosW'(pos);
    c.item_value = val;
    queued_cmds.push_back(c);
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    return value_pool[$urandom_range(7)];
  endfunction

  function automatic logic [2:0] pick_command(mix_t mix);
    int r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (r < 70) return CMD_INSERT;
        if (r < 80) return CMD_GET;
        if (r < 90) return CMD_LOCATE;
        if (r < 95) return CMD_DELETE;
      end
      MIX_DRAIN: begin
        if (r < 60) return CMD_DELETE;
        if (r < 75) return CMD_GET;
        if (r < 90) return CMD_LOCATE;
        if (r < 95) return CMD_INSERT;
      end
      default: begin
        if (r < 30) return CMD_INSERT;
        if (r < 55) return CMD_DELETE;
        if (r < 75) return CMD_GET;
        if (r < 92) return CMD_LOCATE;
        if (r < 96) return CMD_CLEAR;
      end
    endcase
    return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
  endfunction

  // Mostly well-formed positions, tracked against a running length count, with
  // some positions drawn over the whole field.
  function automatic void queue_random_cmds(int count, mix_t mix);
    logic [2:0] cmd;
    int         pos;
    bit         wild;
    for (int n = 0; n < count; n++) begin
      cmd  = pick_command(mix);
      wild = ($urandom_range(99) < 15);
      pos  = $urandom_range(0, 63);
      if (!wild && cmd == CMD_INSERT) begin
        pos = $urandom_range(1, gen_len + 1);
      end else if (!wild && (cmd == CMD_DELETE || cmd == CMD_GET) && gen_len > 0) begin
        pos = $urandom_range(1, gen_len);
      end
      if (cmd == CMD_INSERT && gen_len < LIST_DEPTH && pos >= 1 && pos <= gen_len + 1) begin
        gen_len++;
      end else if (cmd == CMD_DELETE && pos >= 1 && pos <= gen_len) begin
        gen_len--;
      end else if (cmd == CMD_CLEAR) begin
        gen_len = 0;
      end
      queue_cmd(cmd, pos, pick_value());
    end
  endfunction

  task automatic wait_until_quiet();
    while (queued_cmds.size() != 0 || cmd_bus.valid || list_replies_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        list_replies_due.push_back(apply_list_cmd(cmd_bus.payload));
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_bus.valid <= 1'b0;
        end else if (queued_cmds.size() != 0) begin
          cmd_bus.valid   <= 1'b1;
          cmd_bus.payload <= queued_cmds.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall pattern switches among four modes when a random countdown expires.
  always @(posedge clk) begin
    if (!rst_n) begin
      reply_bus.ready <= 1'b0;
      rx_mode      = RX_OPEN;
      rx_mode_left = 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(3));
        rx_mode_left = $urandom_range(20, 120);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN:     reply_bus.ready <= 1'b1;
        RX_COIN:     reply_bus.ready <= 1'($urandom_range(1));
        RX_PERIODIC: reply_bus.ready <= (cycle_count % 4) != 0;
        default:     reply_bus.ready <= ($urandom_range(7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && reply_bus.valid && reply_bus.ready) begin
      if (list_replies_due.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
      end else begin
        want = list_replies_due.pop_front();
        got  = reply_bus.payload;
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
          fail_count++;
        end
        if (got.found_position !== want.found_position) begin
          $error("found_position: expected %0d, actual %0d",
                 want.found_position, got.found_position);
          fail_count++;
        end
        if (got.list_length !== want.list_length) begin
          $error("list_length: expected %0d, actual %0d", want.list_length, got.list_length);
          fail_count++;
        end
        if (got.list_empty !== want.list_empty) begin
          $error("list_empty: expected %0d, actual %0d", want.list_empty, got.list_empty);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    gen_len         = 0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (int i = 5; i < 8; i++) begin
      value_pool[i] = $urandom;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Commands on an empty list, then bad positions around a short list.
    queue_cmd(CMD_GET, 1, 7);
    queue_cmd(CMD_DELETE, 1, 7);
    queue_cmd(CMD_LOCATE, 0, 0);
    queue_cmd(CMD_INSERT, 0, 3);
    queue_cmd(CMD_INSERT, 2, 3);
    queue_cmd(CMD_INSERT, 1, 32'sh8000_0000);
    queue_cmd(CMD_INSERT, 2, 32'sh7fff_ffff);
    queue_cmd(CMD_INSERT, 1, 0);
    queue_cmd(CMD_INSERT, 4, -1);
    queue_cmd(CMD_INSERT, 63, 5);
    queue_cmd(CMD_GET, 0, 0);
    queue_cmd(CMD_GET, 4, 0);
    queue_cmd(CMD_GET, 5, 0);
    queue_cmd(CMD_GET, 63, 0);
    queue_cmd(CMD_LOCATE, 63, 32'sh7fff_ffff);
    queue_cmd(CMD_LOCATE, 0, 12345);
    // A duplicate ahead of the first copy: locate must return the earlier one.
    queue_cmd(CMD_INSERT, 2, 32'sh7fff_ffff);
    queue_cmd(CMD_LOCATE, 0, 32'sh7fff_ffff);
    queue_cmd(CMD_DELETE, 5, 0);
    queue_cmd(CMD_DELETE, 6, 0);
    queue_cmd(CMD_DELETE, 1, 0);
    queue_cmd(CMD_SPARE_LO, 1, -1);
    queue_cmd(3'd6, 2, 32'sh5555_5555);
    queue_cmd(CMD_SPARE_HI, 63, 32'shaaaa_aaaa);
    queue_cmd(CMD_CLEAR, 63, -1);
    queue_cmd(CMD_GET, 1, 0);
    queue_cmd(CMD_LOCATE, 0, 32'sh7fff_ffff);
    wait_until_quiet();

    queue_random_cmds(60, MIX_FILL);
    queue_random_cmds(60, MIX_DRAIN);
    queue_random_cmds(100, MIX_BLEND);
    wait_until_quiet();
    queue_random_cmds(60, MIX_FILL);
    queue_random_cmds(60, MIX_BLEND);
    queue_random_cmds(60, MIX_DRAIN);
    wait_until_quiet();
    repeat (SETTLE_TICKS) @(negedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
